/* src/tcw_pkg.sv */
// tcw_pkg: shared types and constants of the text console writer.
// Holds opcodes, character constants, port widths, controller states and the
// command/status structs passed between tcw_ctrl and tcw_dpath.
`timescale 1ns / 1ps

package tcw_pkg;

  // Default geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Fixed port widths
  localparam int OP_W      = 2;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int IDX_W     = 11;
  localparam int COL_OUT_W = 7;
  localparam int ROW_OUT_W = 5;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'd32;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'd31;

  typedef struct packed {
    logic [ATTR_W-1:0] attr;
    logic [CHAR_W-1:0] ch;
  } cell_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_MOVE,
    ST_MOVE_END,
    ST_FILL,
    ST_CLEAR,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_READ,
    MEM_MOVE_READ,
    MEM_FILL,
    MEM_INIT,
    MEM_PUT
  } mem_op_t;

  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_ZERO,
    CNT_COLS,
    CNT_LASTROW
  } cnt_op_t;

  typedef enum logic [2:0] {
    CUR_NONE,
    CUR_HOME,
    CUR_SCROLL,
    CUR_NEWLINE,
    CUR_PUT
  } cur_op_t;

  typedef struct packed {
    logic    in_ready;
    logic    latch;
    mem_op_t mem_op;
    cnt_op_t cnt_op;
    cur_op_t cur_op;
    logic    out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_put;       // character put (not newline)
    logic is_newline;
    logic is_read;
    logic is_clear;
    logic need_scroll;  // character put must scroll first
    logic row_full;     // cursor row has passed the bottom
    logic cnt_last;     // walk counter at the last cell
    logic out_free;     // output register can take a result
  } dp_stat_t;

endpackage

/* src/tcw_ctrl.sv */
// tcw_ctrl: sequencing state machine of the text console writer.
// Depends on tcw_pkg; drives tcw_dpath through ctl_cmd_t and reads dp_stat_t.
`timescale 1ns / 1ps

module tcw_ctrl import tcw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (stat.cnt_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        priority if (stat.is_clear) begin
          state_nxt = ST_CLEAR;
        end else if ((stat.is_put && stat.need_scroll) ||
                     (stat.is_newline && stat.row_full)) begin
          state_nxt = ST_MOVE;
        end else if (stat.is_put) begin
          state_nxt = ST_WRITE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_MOVE: begin
        if (stat.cnt_last) state_nxt = ST_MOVE_END;
      end
      ST_MOVE_END: begin
        state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (stat.cnt_last) state_nxt = stat.is_put ? ST_WRITE : ST_DONE;
      end
      ST_CLEAR: begin
        if (stat.cnt_last) state_nxt = ST_DONE;
      end
      ST_WRITE: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.mem_op   = MEM_NONE;
    cmd.cnt_op   = CNT_HOLD;
    cmd.cur_op   = CUR_NONE;
    unique case (state_r)
      ST_INIT: begin
        cmd.mem_op = MEM_INIT;
        cmd.cnt_op = CNT_INC;
      end
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.latch    = in_valid;
      end
      ST_DISPATCH: begin
        priority if (stat.is_read) begin
          cmd.mem_op = MEM_READ;
        end else if (stat.is_clear) begin
          cmd.cnt_op = CNT_ZERO;
        end else if ((stat.is_put && stat.need_scroll) ||
                     (stat.is_newline && stat.row_full)) begin
          cmd.cnt_op = CNT_COLS;
        end else if (stat.is_newline) begin
          cmd.cur_op = CUR_NEWLINE;
        end else begin
          cmd.cur_op = CUR_NONE;
        end
      end
      ST_MOVE: begin
        cmd.mem_op = MEM_MOVE_READ;
        cmd.cnt_op = CNT_INC;
      end
      ST_MOVE_END: begin
        // last moved cell is written from the pending slot this cycle
        cmd.cnt_op = CNT_LASTROW;
      end
      ST_FILL: begin
        cmd.mem_op = MEM_FILL;
        cmd.cnt_op = CNT_INC;
        if (stat.cnt_last) cmd.cur_op = CUR_SCROLL;
      end
      ST_CLEAR: begin
        cmd.mem_op = MEM_FILL;
        cmd.cnt_op = CNT_INC;
        if (stat.cnt_last) cmd.cur_op = CUR_HOME;
      end
      ST_WRITE: begin
        cmd.mem_op = MEM_PUT;
        cmd.cur_op = CUR_PUT;
      end
      ST_DONE: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd.in_ready = 1'b0;
      end
    endcase
  end

endmodule

/* src/tcw_dpath.sv */
// tcw_dpath: cell store, cursor, walk counter, attribute and output register.
// Depends on tcw_pkg; commanded by tcw_ctrl.
`timescale 1ns / 1ps

module tcw_dpath import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctl_cmd_t             cmd,
  output dp_stat_t             stat,
  input  logic [OP_W-1:0]      in_op,
  input  logic [CHAR_W-1:0]    in_char_code,
  input  logic [IDX_W-1:0]     in_cell_index,
  input  logic                 cfg_valid,
  input  logic [ATTR_W-1:0]    cfg_text_attribute,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CHAR_W-1:0]    out_cell_char,
  output logic [ATTR_W-1:0]    out_cell_attr,
  output logic [COL_OUT_W-1:0] out_col_out,
  output logic [ROW_OUT_W-1:0] out_row_out
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(COLUMNS + 1);
  localparam int ROW_W      = $clog2(ROWS + 1);
  localparam int CMP_W      = (ADDR_W > IDX_W ? ADDR_W : IDX_W) + 1;

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_ROW  = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [COL_W-1:0]  COL_END   = COL_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  ROW_END   = ROW_W'(ROWS);
  localparam logic [ROW_W-1:0]  ROW_BOT   = ROW_W'(ROWS - 1);

  cell_t mem [CELL_COUNT];
  cell_t rd_data_r;

  logic [OP_W-1:0]   op_r;
  logic [CHAR_W-1:0] char_r;
  logic [IDX_W-1:0]  idx_r;
  logic [ATTR_W-1:0] attr_r;

  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;

  // scroll move: a read issued at cnt is written one row up in the next cycle
  logic              mv_pend_r;
  logic [ADDR_W-1:0] mv_addr_r;

  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r;
  logic [ATTR_W-1:0] out_attr_r;
  logic [COL_OUT_W-1:0] out_col_r;
  logic [ROW_OUT_W-1:0] out_row_r;

  logic              wrapped;
  logic [COL_W-1:0]  put_col;
  logic [ROW_W-1:0]  put_row;
  logic [ADDR_W-1:0] put_addr;
  logic              idx_ok;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  cell_t             wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  // Request fields and configuration
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_op;
      char_r <= in_char_code;
      idx_r  <= in_cell_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= RESET_ATTR;
    end else if (cfg_valid) begin
      attr_r <= cfg_text_attribute;
    end
  end

  // Put position: wrap to the next row when the column ran off the end
  assign wrapped  = (col_r >= COL_END);
  assign put_col  = wrapped ? '0 : col_r;
  assign put_row  = wrapped ? row_r + ROW_W'(1) : row_r;
  assign put_addr = ADDR_W'(put_row) * ROW_STEP + ADDR_W'(put_col);
  assign idx_ok   = CMP_W'(idx_r) < CMP_W'(CELL_COUNT);

  always_comb begin
    stat.is_put      = (op_r == OP_PUT) && (char_r != NEWLINE_CHAR);
    stat.is_newline  = (op_r == OP_PUT) && (char_r == NEWLINE_CHAR);
    stat.is_read     = (op_r == OP_READ);
    stat.is_clear    = (op_r == OP_CLEAR);
    stat.row_full    = (row_r >= ROW_END);
    stat.need_scroll = (row_r >= ROW_END) || (wrapped && (row_r >= ROW_BOT));
    stat.cnt_last    = (cnt_r == LAST_CELL);
    stat.out_free    = !out_valid_r || !out_stall;
  end

  // Walk counter
  always_comb begin
    cnt_nxt = cnt_r;
    unique case (cmd.cnt_op)
      CNT_HOLD:    cnt_nxt = cnt_r;
      CNT_INC:     cnt_nxt = cnt_r + ADDR_W'(1);
      CNT_ZERO:    cnt_nxt = '0;
      CNT_COLS:    cnt_nxt = ROW_STEP;
      CNT_LASTROW: cnt_nxt = LAST_ROW;
      default:     cnt_nxt = cnt_r;
    endcase
  end

  // Cursor
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    unique case (cmd.cur_op)
      CUR_NONE: begin
        col_nxt = col_r;
      end
      CUR_HOME: begin
        col_nxt = '0;
        row_nxt = '0;
      end
      CUR_SCROLL: begin
        col_nxt = '0;
        row_nxt = ROW_BOT;
      end
      CUR_NEWLINE: begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end
      CUR_PUT: begin
        col_nxt = put_col + COL_W'(1);
        row_nxt = put_row;
      end
      default: begin
        col_nxt = col_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      col_r     <= '0;
      row_r     <= '0;
      mv_pend_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      mv_pend_r <= (cmd.mem_op == MEM_MOVE_READ);
    end
  end

  always_ff @(posedge clk) begin
    mv_addr_r <= cnt_r - ROW_STEP;
  end

  // Memory port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r;
    wr_data = '{attr: attr_r, ch: SPACE_CHAR};
    priority if (mv_pend_r) begin
      wr_en   = 1'b1;
      wr_addr = mv_addr_r;
      wr_data = '{attr: attr_r, ch: rd_data_r.ch};
    end else if (cmd.mem_op == MEM_FILL) begin
      wr_en   = 1'b1;
    end else if (cmd.mem_op == MEM_INIT) begin
      wr_en   = 1'b1;
      wr_data = '{attr: RESET_ATTR, ch: SPACE_CHAR};
    end else if (cmd.mem_op == MEM_PUT) begin
      wr_en   = 1'b1;
      wr_addr = put_addr;
      wr_data = '{attr: attr_r, ch: char_r};
    end else begin
      wr_en   = 1'b0;
    end
  end

  assign rd_en   = (cmd.mem_op == MEM_MOVE_READ) ||
                   ((cmd.mem_op == MEM_READ) && idx_ok);
  assign rd_addr = (cmd.mem_op == MEM_MOVE_READ) ? cnt_r : ADDR_W'(idx_r);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_char_r <= (stat.is_read && idx_ok) ? rd_data_r.ch : '0;
      out_attr_r <= (stat.is_read && idx_ok) ? rd_data_r.attr : '0;
      out_col_r  <= COL_OUT_W'(col_r);
      out_row_r  <= ROW_OUT_W'(row_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_cell_char = out_char_r;
  assign out_cell_attr = out_attr_r;
  assign out_col_out   = out_col_r;
  assign out_row_out   = out_row_r;

endmodule

/* src/text_console_writer.sv */
// text_console_writer: top level of the text-mode console.
// Depends on tcw_pkg, tcw_ctrl and tcw_dpath.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request: in_op selects
//   put character, read cell or clear; in_char_code and in_cell_index carry
//   the operands. Every request returns exactly one result on the output
//   channel (out_valid / out_stall): the read cell (zero otherwise) and the
//   cursor column and row after the request.
//   cfg_valid / cfg_ready writes the attribute byte; cfg_ready is always high.
// Steps (C = ROWS*COLUMNS cells; the store has a read and a write port):
//   read, newline, unused op: dispatch, done; a plain character adds one
//   store write. clear: a fill walk over all C cells. Scroll: a walk moving
//   each cell one row up, a fill of the last row, then a character's write.
//   One request is in work at a time; in_stall is high while it runs.
// Reset: a clearing pass writes spaces with attribute 31 to all C cells,
//   with in_stall high; cursor goes to row 0, column 0.
// Stall: a finished result waits in the output register; the next request
//   is accepted meanwhile and its result waits until the register frees.
`timescale 1ns / 1ps

module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      in_op,
  input  logic [CHAR_W-1:0]    in_char_code,
  input  logic [IDX_W-1:0]     in_cell_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CHAR_W-1:0]    out_cell_char,
  output logic [ATTR_W-1:0]    out_cell_attr,
  output logic [COL_OUT_W-1:0] out_col_out,
  output logic [ROW_OUT_W-1:0] out_row_out,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [ATTR_W-1:0]    cfg_text_attribute
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign in_stall  = !cmd.in_ready;
  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcw_dpath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_op              (in_op),
    .in_char_code       (in_char_code),
    .in_cell_index      (in_cell_index),
    .cfg_valid          (cfg_valid),
    .cfg_text_attribute (cfg_text_attribute),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_cell_char      (out_cell_char),
    .out_cell_attr      (out_cell_attr),
    .out_col_out        (out_col_out),
    .out_row_out        (out_row_out)
  );

endmodule

/* src/tcw_checker.sv */
// tcw_checker: port-level assertions for text_console_writer, bound to it.
// Depends on tcw_pkg and the top level's ports.
`timescale 1ns / 1ps

module tcw_checker import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [CHAR_W-1:0]    out_cell_char,
  input logic [ATTR_W-1:0]    out_cell_attr,
  input logic [COL_OUT_W-1:0] out_col_out,
  input logic [ROW_OUT_W-1:0] out_row_out
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cell_char) &&
      $stable(out_cell_attr) && $stable(out_col_out) && $stable(out_row_out))
    else $error("stalled result changed");

  // One request at a time: an accepted request blocks the next cycle.
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted back to back");

  // Cursor never goes past one beyond the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_col_out) <= 32'(COLUMNS)) &&
      (32'(out_row_out) <= 32'(ROWS)))
    else $error("cursor out of range");

  // A new result only follows work on a request.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in work");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (.*);

/* dv/tb_text_console_writer.sv */
// tb_text_console_writer: self-checking testbench of the text console writer.
// Predicts cursor and read-back cells from its own screen model; needs tcw_pkg
// and the text_console_writer RTL.
`timescale 1ns / 1ps

import tcw_pkg::*;

localparam int SCREEN_CELLS = DEF_COLUMNS * DEF_ROWS;

typedef struct packed {
  logic [CHAR_W-1:0]    ch;
  logic [ATTR_W-1:0]    attr;
  logic [COL_OUT_W-1:0] col;
  logic [ROW_OUT_W-1:0] row;
} console_result_t;

class console_scoreboard;
  cell_t             cells [SCREEN_CELLS];
  int unsigned       cur_col;
  int unsigned       cur_row;
  logic [ATTR_W-1:0] attr;
  console_result_t   expected_q [$];
  int unsigned       mismatches;

  function new();
    attr = RESET_ATTR;
    blank_screen();
    cur_col = 0;
    cur_row = 0;
    mismatches = 0;
  endfunction

  function void blank_screen();
    for (int i = 0; i < SCREEN_CELLS; i++) cells[i] = {attr, SPACE_CHAR};
  endfunction

  // Characters move up one row and all take the current attribute.
  function void scroll_up();
    for (int i = DEF_COLUMNS; i < SCREEN_CELLS; i++)
      cells[i - DEF_COLUMNS] = {attr, cells[i].ch};
    for (int i = DEF_COLUMNS * (DEF_ROWS - 1); i < SCREEN_CELLS; i++)
      cells[i] = {attr, SPACE_CHAR};
    cur_row = DEF_ROWS - 1;
    cur_col = 0;
  endfunction

  function void advance_line();
    if (cur_row >= DEF_ROWS) begin
      scroll_up();
    end else begin
      cur_col = 0;
      cur_row++;
    end
  endfunction

  function void put_char(input logic [CHAR_W-1:0] code);
    if (code == NEWLINE_CHAR) begin
      advance_line();
      return;
    end
    if (cur_row >= DEF_ROWS) scroll_up();
    if (cur_col >= DEF_COLUMNS) advance_line();
    // a wrap on the last row pushes the cursor below the screen again
    if (cur_row >= DEF_ROWS) scroll_up();
    cells[cur_row * DEF_COLUMNS + cur_col] = {attr, code};
    cur_col++;
  endfunction

  function void note_request(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] code,
                             input logic [IDX_W-1:0] idx);
    console_result_t r;
    r = '0;
    case (op)
      OP_PUT: put_char(code);
      OP_READ: begin
        if (idx < SCREEN_CELLS) begin
          r.ch   = cells[idx].ch;
          r.attr = cells[idx].attr;
        end
      end
      OP_CLEAR: begin
        blank_screen();
        cur_col = 0;
        cur_row = 0;
      end
      default: ;
    endcase
    r.col = COL_OUT_W'(cur_col);
    r.row = ROW_OUT_W'(cur_row);
    expected_q.push_back(r);
  endfunction

  function void check_result(input logic [CHAR_W-1:0] ch, input logic [ATTR_W-1:0] at,
                             input logic [COL_OUT_W-1:0] col,
                             input logic [ROW_OUT_W-1:0] row);
    console_result_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: char %0d attr %0d col %0d row %0d", ch, at, col, row);
      return;
    end
    want = expected_q.pop_front();
    if (want.ch !== ch || want.attr !== at || want.col !== col || want.row !== row) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch at %0t: expected char %0d attr %0d col %0d row %0d, got %0d %0d %0d %0d",
                 $realtime, want.ch, want.attr, want.col, want.row, ch, at, col, row);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_text_console_writer;
  // a slow run has a few hundred scrolls and clears, each a walk over the screen
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int PHASE_REQUESTS = 500;
  localparam int HOLD_CYCLES = 400;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [OP_W-1:0]      in_op;
  logic [CHAR_W-1:0]    in_char_code;
  logic [IDX_W-1:0]     in_cell_index;
  logic                 out_valid;
  logic                 out_stall;
  logic [CHAR_W-1:0]    out_cell_char;
  logic [ATTR_W-1:0]    out_cell_attr;
  logic [COL_OUT_W-1:0] out_col_out;
  logic [ROW_OUT_W-1:0] out_row_out;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [ATTR_W-1:0]    cfg_text_attribute;

  console_scoreboard sb;
  bit                quiet;
  bit                hold_request;
  int                requests_sent;
  int unsigned       cycle_count = 0;

  text_console_writer u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_char_code       (in_char_code),
    .in_cell_index      (in_cell_index),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_cell_char      (out_cell_char),
    .out_cell_attr      (out_cell_attr),
    .out_col_out        (out_col_out),
    .out_row_out        (out_row_out),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_text_attribute (cfg_text_attribute)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_text_console_writer failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_cell_char, out_cell_attr, out_col_out, out_row_out);
  end

  // Result side back-pressure: short bursts, calm stretches, one long hold.
  initial begin : result_sink
    int idle_left;
    int calm_left;
    out_stall = 1'b0;
    idle_left = 0;
    calm_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        out_stall <= 1'b1;
      end else if (quiet || calm_left > 0) begin
        if (calm_left > 0) calm_left--;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        idle_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 100);
        out_stall <= 1'b0;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] code,
                              input logic [IDX_W-1:0] idx);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_char_code  <= code;
    in_cell_index <= idx;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_request(op, code, idx);
    if (op != OP_UNUSED) requests_sent++;
    @(negedge clk);
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    int unsigned r;
    int unsigned line;
    r = $urandom_range(0, 9);
    line = (sb.cur_row < DEF_ROWS) ? sb.cur_row : DEF_ROWS - 1;
    if (r < 8) return IDX_W'($urandom_range(0, SCREEN_CELLS - 1));
    if (r == 8) return IDX_W'(line * DEF_COLUMNS + $urandom_range(0, DEF_COLUMNS - 1));
    return IDX_W'($urandom_range(SCREEN_CELLS, (1 << IDX_W) - 1));
  endfunction

  task automatic send_line(input int unsigned len, input bit end_line);
    for (int unsigned i = 0; i < len; i++) begin
      send_request(OP_PUT, CHAR_W'($urandom_range(0, 255)), IDX_W'($urandom));
      if ($urandom_range(0, 5) == 0) send_request(OP_READ, CHAR_W'($urandom), pick_index());
    end
    if (end_line) send_request(OP_PUT, NEWLINE_CHAR, IDX_W'($urandom));
  endtask

  // Short lines to the last row, a wrap there, a newline off it, a character
  // below the screen, a newline off the last row and one below the screen.
  task automatic walk_to_bottom();
    while (sb.cur_row < DEF_ROWS - 1) send_line($urandom_range(0, 3), 1'b1);
    send_line(DEF_COLUMNS + $urandom_range(1, 10), 1'b1);
    send_line(1, 1'b1);
    send_request(OP_PUT, NEWLINE_CHAR, IDX_W'($urandom));
  endtask

  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    cfg_valid          <= 1'b1;
    cfg_text_attribute <= value;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.attr = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    int first;
    int unsigned kind;
    int unsigned r;
    first = requests_sent;
    walk_to_bottom();
    while (requests_sent - first < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        r = $urandom_range(0, 99);
        if (r < 60)      send_line($urandom_range(0, 4), $urandom_range(0, 9) != 0);
        else if (r < 85) send_line($urandom_range(5, 40), $urandom_range(0, 9) != 0);
        else             send_line($urandom_range(70, 170), $urandom_range(0, 9) != 0);
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 8)) send_request(OP_READ, CHAR_W'($urandom), pick_index());
      end else if (kind < 96) begin
        send_request(OP_W'($urandom_range(0, 3)), CHAR_W'($urandom), IDX_W'($urandom));
      end else if (kind < 98) begin
        send_request(OP_CLEAR, CHAR_W'($urandom), IDX_W'($urandom));
      end else begin
        wait_drained(2);
      end
    end
  endtask

  initial begin
    sb                 = new();
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_op              = OP_PUT;
    in_char_code       = '0;
    in_cell_index      = '0;
    cfg_valid          = 1'b0;
    cfg_text_attribute = '0;
    quiet              = 1'b0;
    hold_request       = 1'b0;
    requests_sent      = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // cells as left by the reset clearing pass, out-of-range reads, unused op
    send_request(OP_READ, '0, IDX_W'(0));
    send_request(OP_READ, '0, IDX_W'(SCREEN_CELLS - 1));
    send_request(OP_READ, '0, IDX_W'(SCREEN_CELLS));
    send_request(OP_READ, '0, '1);
    send_request(OP_UNUSED, '1, '1);
    wait_drained(8);
    write_attribute(8'h00);

    send_request(OP_PUT, 8'h00, '0);
    send_request(OP_PUT, 8'hFF, '1);
    send_request(OP_READ, '0, IDX_W'(0));
    send_request(OP_READ, '0, IDX_W'(1));
    send_request(OP_PUT, NEWLINE_CHAR, '0);
    wait_drained(8);
    write_attribute(8'hFF);

    send_request(OP_PUT, 8'h55, '0);
    send_request(OP_PUT, 8'hAA, '0);
    send_request(OP_READ, '0, IDX_W'(DEF_COLUMNS));
    send_request(OP_READ, '0, IDX_W'(DEF_COLUMNS + 1));
    send_request(OP_CLEAR, '1, '1);
    send_request(OP_READ, '0, IDX_W'(0));
    send_request(OP_READ, '0, IDX_W'(SCREEN_CELLS - 1));
    send_request(OP_PUT, 8'h41, '0);

    for (int phase = 0; phase < 4; phase++) begin
      wait_drained(8);
      write_attribute(ATTR_W'($urandom_range(0, 255)));
      quiet = (phase == 3);
      if (phase == 1) hold_request = 1'b1;
      random_phase(PHASE_REQUESTS);
    end

    wait_drained(16);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("tb_text_console_writer passed");
    else
      $display("tb_text_console_writer failed");
    $finish;
  end
endmodule
